>>> design/cbm_pkg.sv
// ----------------------------------------------------------------------------
// Codebook background model package
// Shared types and operation codes for the codebook background model core.
// ----------------------------------------------------------------------------
package cbm_pkg;

   typedef enum logic [1:0] {
      OP_LEARN  = 2'd0,
      OP_DETECT = 2'd1,
      OP_PURGE  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_BOUND0 = 3'd0,
      CSR_BOUND1 = 3'd1,
      CSR_BOUND2 = 3'd2,
      CSR_MINMRG = 3'd3,
      CSR_MAXMRG = 3'd4
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HEAD,
      ST_HWAIT,
      ST_READ,
      ST_RWAIT,
      ST_EVAL,
      ST_APPEND,
      ST_NUDGE,
      ST_NWAIT,
      ST_NWRITE,
      ST_TAIL,
      ST_DONE
   } state_type;

   localparam int CH_MAX = 3;

   typedef struct packed {
      logic [CH_MAX-1:0][7:0] lhi;
      logic [CH_MAX-1:0][7:0] llo;
      logic [CH_MAX-1:0][7:0] rmax;
      logic [CH_MAX-1:0][7:0] rmin;
      logic [15:0]            last;
      logic [15:0]            stale;
   } word_type;

endpackage

>>> design/codebook_background_model_core.sv
// ----------------------------------------------------------------------------
// Codebook background model core
// Per-pixel codebook: learn, detect and purge over one codeword memory with a
// single compare/update unit stepping through the book one codeword at a time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake    | payload
//  req     | in        | valid, stall | operation, pixel_index, chan0..chan2
//  rsp     | out       | valid, stall | foreground, entry_index, book_full,
//          |           |              | cleared_count
//  csr     | in        | valid, ready | addr, data
// Each codeword read takes a read wait state and an evaluate state on the
// codeword memory, a learn that updates a codeword adds a nudge state, and
// detect stops at the first covering codeword.
// Reset clears the per-pixel head memory in one pass over every pixel, during
// which no item is taken. The result waits in its register while rsp
// is stalled and the next item is held off until it is taken.
module codebook_background_model_core
   import cbm_pkg::*;
#(
   parameter int PIXEL_COUNT = 131072,
   parameter int MAX_ENTRIES = 8,
   parameter int CHANNELS    = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [16:0] req_pixel_index,
   input  logic [7:0]  req_chan0,
   input  logic [7:0]  req_chan1,
   input  logic [7:0]  req_chan2,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_foreground,
   output logic [2:0]  rsp_entry_index,
   output logic        rsp_book_full,
   output logic [3:0]  rsp_cleared_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [8:0]  csr_data
);

   localparam int PW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int SW = PW + EW;

   // Head memory: entry count and pixel clock per pixel.
   logic [CW+15:0] head_mem [PIXEL_COUNT];
   logic [CW+15:0] head_rd_ff;
   logic           head_we;
   logic [PW-1:0]  head_wa;
   logic [CW+15:0] head_wd;
   // Codeword memory.
   word_type       word_mem [PIXEL_COUNT*(2**EW)];
   word_type       word_rd_ff;
   logic           word_we;
   logic [SW-1:0]  word_wa, word_ra;
   word_type       word_wd;

   state_type state_ff, state_in;
   logic [PW:0]  clr_ff, clr_in;
   logic [PW-1:0] pix_ff, pix_in;
   op_type       op_ff, op_in;
   logic [CH_MAX-1:0][7:0] v_ff, v_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0]   clk_ff, clk_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic [CW-1:0] hit_ff, hit_in;
   logic          found_ff, found_in;
   word_type      hitw_ff, hitw_in;
   logic          rv_ff, rv_in, fg_ff, fg_in, full_ff, full_in;
   logic [2:0]    ei_ff, ei_in;
   logic [3:0]    cc_ff, cc_in;
   logic [CH_MAX-1:0][7:0] bnd_ff;
   logic signed [8:0] minm_ff, maxm_ff;

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      head_rd_ff <= head_mem[pix_ff];
      if (word_we) word_mem[word_wa] <= word_wd;
      word_rd_ff <= word_mem[word_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_ff  <= {8'd5, 8'd5, 8'd10};
         minm_ff <= 9'sd20;
         maxm_ff <= 9'sd20;
      end else if (csr_valid && csr_ready) begin
         case (csr_addr)
            CSR_BOUND0: bnd_ff[0] <= csr_data[7:0];
            CSR_BOUND1: bnd_ff[1] <= csr_data[7:0];
            CSR_BOUND2: bnd_ff[2] <= csr_data[7:0];
            CSR_MINMRG: minm_ff <= csr_data;
            CSR_MAXMRG: maxm_ff <= csr_data;
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // Per-channel target window and compare unit on the codeword being read.
   logic [CH_MAX-1:0][7:0] thi, tlo;
   logic lmatch, dcover;
   logic [15:0] run;
   always_comb begin
      lmatch = 1'b1;
      dcover = 1'b1;
      for (int n = 0; n < CH_MAX; n++) begin
         logic [8:0] h;
         logic signed [10:0] lo_s, hi_s, x;
         h = {1'b0, v_ff[n]} + {1'b0, bnd_ff[n]};
         thi[n] = h[8] ? 8'hFF : h[7:0];
         tlo[n] = (v_ff[n] > bnd_ff[n]) ? v_ff[n] - bnd_ff[n] : 8'd0;
         lo_s = $signed({3'b000, word_rd_ff.rmin[n]}) - 11'(minm_ff);
         hi_s = $signed({3'b000, word_rd_ff.rmax[n]}) + 11'(maxm_ff);
         x = $signed({3'b000, v_ff[n]});
         if (n < CHANNELS) begin
            if (!(word_rd_ff.llo[n] <= v_ff[n] && v_ff[n] <= word_rd_ff.lhi[n]))
               lmatch = 1'b0;
            if (!(lo_s <= x && x <= hi_s)) dcover = 1'b0;
         end
      end
   end

   word_type upd;
   always_comb begin
      logic [15:0] lm;
      upd = word_rd_ff;
      lm = word_rd_ff.last;
      if (lmatch && !found_ff) begin
         upd.last = clk_ff;
         lm = clk_ff;
         for (int n = 0; n < CHANNELS; n++) begin
            if (word_rd_ff.rmax[n] < v_ff[n]) upd.rmax[n] = v_ff[n];
            else if (word_rd_ff.rmin[n] > v_ff[n]) upd.rmin[n] = v_ff[n];
         end
      end
      run = (clk_ff >= lm) ? clk_ff - lm : 16'd0;
      if (upd.stale < run) upd.stale = run;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HEAD;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
      pix_ff <= pix_in; op_ff <= op_in; v_ff <= v_in; cnt_ff <= cnt_in;
      clk_ff <= clk_in; idx_ff <= idx_in; kept_ff <= kept_in; hit_ff <= hit_in;
      found_ff <= found_in; hitw_ff <= hitw_in; fg_ff <= fg_in;
      full_ff <= full_in; ei_ff <= ei_in; cc_ff <= cc_in;
   end

   logic clearing;
   assign clearing = (clr_ff < (PW+1)'(PIXEL_COUNT));

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; pix_in = pix_ff; op_in = op_ff;
      v_in = v_ff; cnt_in = cnt_ff; clk_in = clk_ff; idx_in = idx_ff;
      kept_in = kept_ff; hit_in = hit_ff; found_in = found_ff; hitw_in = hitw_ff;
      rv_in = rv_ff; fg_in = fg_ff; full_in = full_ff; ei_in = ei_ff; cc_in = cc_ff;
      head_we = 1'b0; head_wa = pix_ff; head_wd = '0;
      word_we = 1'b0; word_wa = '0; word_wd = upd;
      word_ra = SW'({pix_ff, {EW{1'b0}}}) + SW'(idx_ff);
      req_stall = 1'b1;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (state_ff)
         ST_HEAD: begin
            if (clearing) begin
               head_we = 1'b1; head_wa = clr_ff[PW-1:0]; clr_in = clr_ff + 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = rv_ff;
            if (req_valid && !rv_ff) begin
               pix_in = req_pixel_index[PW-1:0];
               op_in = op_type'(req_operation);
               v_in = {req_chan2, req_chan1, req_chan0};
               idx_in = '0; kept_in = '0; found_in = 1'b0; hit_in = '0;
               fg_in = 1'b0; full_in = 1'b0; ei_in = '0; cc_in = '0;
               if (32'(req_pixel_index) >= PIXEL_COUNT || req_operation == OP_NONE)
                  state_in = ST_DONE;
               else
                  state_in = ST_HWAIT;
            end
         end
         ST_HWAIT: state_in = ST_READ;
         ST_READ: begin
            cnt_in = head_rd_ff[CW+15:16];
            clk_in = head_rd_ff[15:0];
            if (op_ff == OP_LEARN && head_rd_ff[15:0] != 16'hFFFF)
               clk_in = head_rd_ff[15:0] + 16'd1;
            fg_in = (op_ff == OP_DETECT);
            state_in = ST_APPEND;
            if (head_rd_ff[CW+15:16] != '0) state_in = ST_RWAIT;
         end
         ST_RWAIT: state_in = ST_EVAL;
         ST_EVAL: begin
            state_in = ST_RWAIT;
            case (op_ff)
               OP_LEARN: begin
                  word_we = 1'b1; word_wa = word_ra;
                  if (lmatch && !found_ff) begin
                     found_in = 1'b1; hit_in = idx_ff; hitw_in = upd;
                  end
               end
               OP_DETECT: if (dcover) fg_in = 1'b0;
               default: begin
                  if (word_rd_ff.stale <= {1'b0, clk_ff[15:1]}) begin
                     word_we = 1'b1;
                     word_wa = SW'({pix_ff, {EW{1'b0}}}) + SW'(kept_ff);
                     word_wd = word_rd_ff; word_wd.last = '0;
                     kept_in = kept_ff + 1'b1;
                  end
               end
            endcase
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == cnt_ff || (op_ff == OP_DETECT && dcover))
               state_in = ST_APPEND;
         end
         ST_APPEND: begin
            state_in = ST_TAIL;
            if (op_ff == OP_LEARN) begin
               state_in = ST_NUDGE;
               if (!found_ff) begin
                  if (cnt_ff == CW'(MAX_ENTRIES)) begin
                     full_in = 1'b1; state_in = ST_TAIL;
                  end else begin
                     hit_in = cnt_ff; cnt_in = cnt_ff + 1'b1;
                     hitw_in.lhi = thi; hitw_in.llo = tlo;
                     hitw_in.rmax = v_ff; hitw_in.rmin = v_ff;
                     hitw_in.last = clk_ff; hitw_in.stale = '0;
                  end
               end
            end
         end
         ST_NUDGE: begin
            word_we = 1'b1;
            word_wa = SW'({pix_ff, {EW{1'b0}}}) + SW'(hit_ff);
            word_wd = hitw_ff;
            for (int n = 0; n < CHANNELS; n++) begin
               if (hitw_ff.lhi[n] < thi[n]) word_wd.lhi[n] = hitw_ff.lhi[n] + 8'd1;
               if (hitw_ff.llo[n] > tlo[n]) word_wd.llo[n] = hitw_ff.llo[n] - 8'd1;
            end
            ei_in = 3'(hit_ff);
            state_in = ST_TAIL;
         end
         ST_TAIL: begin
            head_we = 1'b1;
            case (op_ff)
               OP_PURGE: begin
                  head_wd = {kept_ff, 16'd0};
                  cc_in = 4'(cnt_ff - kept_ff);
               end
               OP_LEARN: head_wd = {cnt_ff, clk_ff};
               default:  head_wd = {cnt_ff, clk_ff};
            endcase
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_foreground = fg_ff;
   assign rsp_entry_index = ei_ff;
   assign rsp_book_full = full_ff;
   assign rsp_cleared_count = cc_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff && $stable(cc_ff))
      else $error("result changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == ST_IDLE && !rv_ff)
      else $error("item accepted while busy");
   a_full_index: assert property (@(posedge clock) disable iff (reset)
      rv_ff && full_ff |-> ei_ff == 3'd0)
      else $error("full book with nonzero index");
endmodule

>>> test/cbm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Codebook background model checker
// Watches the request, result and register channels of the core, keeps its own
// copy of every touched pixel's codebook, predicts each result and compares it
// field by field with what the core returns.
// ----------------------------------------------------------------------------
module cbm_checker
   import cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [16:0] req_pixel_index,
   input  logic [7:0]  req_chan0,
   input  logic [7:0]  req_chan1,
   input  logic [7:0]  req_chan2,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_foreground,
   input  logic [2:0]  rsp_entry_index,
   input  logic        rsp_book_full,
   input  logic [3:0]  rsp_cleared_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [8:0]  csr_data,
   output int          mismatches,
   output int          outstanding,
   output int          results_seen,
   output int          full_seen,
   output int          purged_seen
);

   localparam int BOOK_DEPTH = 8;

   typedef struct {
      logic       foreground;
      logic [2:0] entry_index;
      logic       book_full;
      logic [3:0] cleared_count;
   } verdict_type;

   verdict_type   awaited[$];
   word_type      words[int];
   int unsigned   book_size[int];
   logic [15:0]   clocks[int];
   logic [7:0]    bound[3];
   int            min_mrg;
   int            max_mrg;

   assign outstanding = awaited.size();

   task automatic report(input string field, input int got, input int want);
      $display("tb: %t %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   function automatic verdict_type learn(input int pix, input logic [7:0] v[3]);
      verdict_type r;
      int unsigned cnt;
      int unsigned i;
      logic [15:0] clk;
      logic [15:0] run;
      logic [7:0] hi[3];
      logic [7:0] lo[3];
      logic found;
      logic ok;
      word_type w;
      r = '{0, 0, 0, 0};
      cnt = book_size.exists(pix) ? book_size[pix] : 0;
      clk = clocks.exists(pix) ? clocks[pix] : 16'd0;
      if (clk != 16'hFFFF) begin
         clk++;
      end
      clocks[pix] = clk;
      for (int n = 0; n < 3; n++) begin
         hi[n] = (int'(v[n]) + int'(bound[n]) > 255) ? 8'd255 : v[n] + bound[n];
         lo[n] = (v[n] > bound[n]) ? v[n] - bound[n] : 8'd0;
      end
      found = 0;
      for (i = 0; i < cnt; i++) begin
         w = words[pix * BOOK_DEPTH + i];
         ok = 1;
         for (int n = 0; n < 3; n++) begin
            if (!(w.llo[n] <= v[n] && v[n] <= w.lhi[n])) begin
               ok = 0;
            end
         end
         if (ok) begin
            w.last = clk;
            for (int n = 0; n < 3; n++) begin
               if (w.rmax[n] < v[n]) begin
                  w.rmax[n] = v[n];
               end else if (w.rmin[n] > v[n]) begin
                  w.rmin[n] = v[n];
               end
            end
            words[pix * BOOK_DEPTH + i] = w;
            found = 1;
            break;
         end
      end
      for (int s = 0; s < cnt; s++) begin
         w = words[pix * BOOK_DEPTH + s];
         run = (clk >= w.last) ? clk - w.last : 16'd0;
         if (w.stale < run) begin
            w.stale = run;
         end
         words[pix * BOOK_DEPTH + s] = w;
      end
      if (!found) begin
         if (cnt >= BOOK_DEPTH) begin
            r.book_full = 1;
            return r;
         end
         for (int n = 0; n < 3; n++) begin
            w.lhi[n] = hi[n];
            w.llo[n] = lo[n];
            w.rmax[n] = v[n];
            w.rmin[n] = v[n];
         end
         w.last = clk;
         w.stale = 0;
         words[pix * BOOK_DEPTH + cnt] = w;
         book_size[pix] = cnt + 1;
         i = cnt;
      end
      w = words[pix * BOOK_DEPTH + i];
      for (int n = 0; n < 3; n++) begin
         if (w.lhi[n] < hi[n]) begin
            w.lhi[n]++;
         end
         if (w.llo[n] > lo[n]) begin
            w.llo[n]--;
         end
      end
      words[pix * BOOK_DEPTH + i] = w;
      r.entry_index = i[2:0];
      return r;
   endfunction

   function automatic verdict_type detect(input int pix, input logic [7:0] v[3]);
      verdict_type r;
      int unsigned cnt;
      logic ok;
      word_type w;
      r = '{1, 0, 0, 0};
      cnt = book_size.exists(pix) ? book_size[pix] : 0;
      for (int i = 0; i < cnt; i++) begin
         w = words[pix * BOOK_DEPTH + i];
         ok = 1;
         for (int n = 0; n < 3; n++) begin
            if (!(int'(w.rmin[n]) - min_mrg <= int'(v[n]) &&
                  int'(v[n]) <= int'(w.rmax[n]) + max_mrg)) begin
               ok = 0;
            end
         end
         if (ok) begin
            r.foreground = 0;
            return r;
         end
      end
      return r;
   endfunction

   function automatic verdict_type purge(input int pix);
      verdict_type r;
      int unsigned cnt;
      int unsigned kept;
      logic [15:0] thresh;
      word_type w;
      r = '{0, 0, 0, 0};
      cnt = book_size.exists(pix) ? book_size[pix] : 0;
      thresh = (clocks.exists(pix) ? clocks[pix] : 16'd0) >> 1;
      kept = 0;
      for (int i = 0; i < cnt; i++) begin
         w = words[pix * BOOK_DEPTH + i];
         if (w.stale > thresh) begin
            continue;
         end
         w.last = 0;
         words[pix * BOOK_DEPTH + kept] = w;
         kept++;
      end
      clocks[pix] = 0;
      book_size[pix] = kept;
      r.cleared_count = 4'(cnt - kept);
      return r;
   endfunction

   always @(posedge clock) begin
      logic [7:0] v[3];
      verdict_type want;
      if (reset) begin
         bound[0] <= 8'd10;
         bound[1] <= 8'd5;
         bound[2] <= 8'd5;
         min_mrg <= 20;
         max_mrg <= 20;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_BOUND0: bound[0] <= csr_data[7:0];
               CSR_BOUND1: bound[1] <= csr_data[7:0];
               CSR_BOUND2: bound[2] <= csr_data[7:0];
               CSR_MINMRG: min_mrg <= int'($signed(csr_data));
               CSR_MAXMRG: max_mrg <= int'($signed(csr_data));
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            v[0] = req_chan0;
            v[1] = req_chan1;
            v[2] = req_chan2;
            case (op_type'(req_operation))
               OP_LEARN:  want = learn(int'(req_pixel_index), v);
               OP_DETECT: want = detect(int'(req_pixel_index), v);
               OP_PURGE:  want = purge(int'(req_pixel_index));
               default:   want = '{0, 0, 0, 0};
            endcase
            awaited.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_book_full) begin
               full_seen++;
            end
            if (rsp_cleared_count != 0) begin
               purged_seen++;
            end
            if (awaited.size() == 0) begin
               report("unexpected result", 1, 0);
            end else begin
               want = awaited.pop_front();
               if (rsp_foreground !== want.foreground) begin
                  report("foreground", rsp_foreground, want.foreground);
               end
               if (rsp_entry_index !== want.entry_index) begin
                  report("entry_index", rsp_entry_index, want.entry_index);
               end
               if (rsp_book_full !== want.book_full) begin
                  report("book_full", rsp_book_full, want.book_full);
               end
               if (rsp_cleared_count !== want.cleared_count) begin
                  report("cleared_count", rsp_cleared_count, want.cleared_count);
               end
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      results_seen = 0;
      full_seen = 0;
      purged_seen = 0;
   end

endmodule

>>> test/tb_codebook_background_model_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Codebook background model core testbench
// Drives learn, detect, purge and no-operation items with random gaps and result
// stalls across several register settings; the checker beside the core predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_codebook_background_model_core
   import cbm_pkg::*;
;

   localparam int          CYCLE_LIMIT = 2000000;
   localparam int          POOL_SIZE   = 12;
   localparam logic [2:0]  CSR_SPARE   = 3'd7;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_LEARN;
   logic [16:0] req_pixel_index = 0;
   logic [7:0]  req_chan0 = 0;
   logic [7:0]  req_chan1 = 0;
   logic [7:0]  req_chan2 = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_foreground;
   logic [2:0]  rsp_entry_index;
   logic        rsp_book_full;
   logic [3:0]  rsp_cleared_count;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_addr = 0;
   logic [8:0]  csr_data = 0;

   int          mismatches;
   int          outstanding;
   int          results_seen;
   int          full_seen;
   int          purged_seen;
   int          cycles = 0;
   int          items_sent = 0;
   logic        steady = 0;
   logic        long_hold = 0;
   logic [16:0] pool_pix[POOL_SIZE];
   logic [7:0]  pool_col[POOL_SIZE][3];

   always #5 clock = ~clock;

   codebook_background_model_core dut (.*);

   cbm_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int w;
      forever begin
         w = steady ? 0 : $urandom_range(0, 6);
         if (long_hold) begin
            w = 400;
            long_hold = 0;
         end
         if (w > 0) begin
            rsp_stall <= 1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send(input op_type op, input logic [16:0] pix,
                       input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_pixel_index <= pix;
      req_chan0 <= c0;
      req_chan1 <= c1;
      req_chan2 <= c2;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [8:0] value);
      csr_valid <= 1;
      csr_addr <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic setup(input logic [8:0] b0, input logic [8:0] b1, input logic [8:0] b2,
                        input logic [8:0] mn, input logic [8:0] mx);
      write_reg(CSR_BOUND0, b0);
      write_reg(CSR_BOUND1, b1);
      write_reg(CSR_BOUND2, b2);
      write_reg(CSR_MINMRG, mn);
      write_reg(CSR_MAXMRG, mx);
   endtask

   function automatic logic [7:0] near(input logic [7:0] base);
      int x;
      x = int'(base) + $urandom_range(0, 24) - 12;
      return (x < 0) ? 8'd0 : (x > 255) ? 8'd255 : 8'(x);
   endfunction

   task automatic random_items(input int count);
      int k;
      int sel;
      op_type op;
      logic [16:0] pix;
      for (int j = 0; j < count; j++) begin
         sel = $urandom_range(0, 99);
         op = (sel < 60) ? OP_LEARN : (sel < 90) ? OP_DETECT : (sel < 97) ? OP_PURGE : OP_NONE;
         k = $urandom_range(0, POOL_SIZE - 1);
         if ($urandom_range(0, 9) == 0) begin
            pix = 17'($urandom);
            send(op, pix, 8'($urandom), 8'($urandom), 8'($urandom));
         end else if ($urandom_range(0, 4) == 0) begin
            send(op, pool_pix[k], 8'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            send(op, pool_pix[k], near(pool_col[k][0]), near(pool_col[k][1]),
                 near(pool_col[k][2]));
         end
      end
   endtask

   initial begin
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_pix[k] = (k == 0) ? 17'd0 : (k == 1) ? 17'h1FFFF : 17'($urandom);
         for (int n = 0; n < 3; n++) begin
            pool_col[k][n] = 8'($urandom);
         end
      end
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_reg(CSR_SPARE, 9'h1FF);

      send(OP_DETECT, 17'd0, 8'd0, 8'd0, 8'd0);
      send(OP_PURGE, 17'd0, 8'd0, 8'd0, 8'd0);
      send(OP_LEARN, 17'd0, 8'd0, 8'd0, 8'd0);
      send(OP_LEARN, 17'd0, 8'd3, 8'd2, 8'd1);
      send(OP_LEARN, 17'd0, 8'd255, 8'd255, 8'd255);
      send(OP_DETECT, 17'd0, 8'd15, 8'd10, 8'd10);
      send(OP_DETECT, 17'd0, 8'd128, 8'd128, 8'd128);
      send(OP_LEARN, 17'h1FFFF, 8'hAA, 8'h55, 8'hAA);
      send(OP_DETECT, 17'h1FFFF, 8'h55, 8'hAA, 8'h55);
      send(OP_NONE, 17'h1FFFF, 8'hFF, 8'hFF, 8'hFF);
      for (int j = 0; j < 9; j++) begin
         send(OP_LEARN, 17'd5, 8'(j * 30), 8'(255 - j * 30), 8'(j * 17));
      end
      send(OP_LEARN, 17'd5, 8'd0, 8'd255, 8'd0);
      send(OP_PURGE, 17'd5, 8'd0, 8'd0, 8'd0);
      send(OP_PURGE, 17'd0, 8'd0, 8'd0, 8'd0);
      send(OP_DETECT, 17'd5, 8'd0, 8'd255, 8'd0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: setup(9'd10, 9'd5, 9'd5, 9'd20, 9'd20);
            1: setup(9'd0, 9'd0, 9'd0, 9'h101, 9'h101);
            2: setup(9'd255, 9'd255, 9'd255, 9'd255, 9'd255);
            3: setup(9'd3, 9'd8, 9'd1, 9'd0, 9'd0);
            4: setup(9'h1FF, 9'h100, 9'd7, 9'h1F6, 9'd40);
            default: setup(9'($urandom), 9'($urandom), 9'($urandom),
                           9'($urandom), 9'($urandom));
         endcase
         steady = (phase == 3);
         if (phase == 2) begin
            long_hold = 1;
         end
         random_items(250);
         drain();
      end

      $display("tb: %0d items sent, %0d results checked over six register settings",
               items_sent, results_seen);
      $display("tb: %0d full-book results, %0d purges that removed codewords",
               full_seen, purged_seen);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
design/cbm_pkg.sv
design/codebook_background_model_core.sv
test/cbm_checker.sv
test/tb_codebook_background_model_core.sv
